// File: design/asp_pkg.sv
`default_nettype none
// ============================================================================
// asp_pkg: shared types and codes of the A* shortest path engine
// Operation codes, register indexes and the control structures exchanged
// between the sequencer and its storage units.
// ============================================================================
package asp_pkg;

   // Operation codes of an input transaction.
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_EDGE  = 2'd1;
   localparam logic [1:0] FUNC_HEUR  = 2'd2;
   localparam logic [1:0] FUNC_RUN   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_START = 1'b0;
   localparam logic CSR_GOAL  = 1'b1;

   // Commands to the frontier unit.
   typedef struct packed {
      logic clr;
      logic push;
      logic scan;
      logic kill;
   } fr_cmd_type;

   // Status from the frontier unit.
   typedef struct packed {
      logic done;
      logic empty;
   } fr_stat_type;

   // Load commands to the graph tables.
   typedef struct packed {
      logic clr;
      logic add_edge;
      logic set_heur;
   } ld_cmd_type;

endpackage
`default_nettype wire

// File: design/asp_graph.sv
`default_nettype none
// ============================================================================
// asp_graph: edge list and heuristic tables
// Holds the loaded edges and per-state heuristics, each with one registered
// read port. Heuristics that were never loaded read as zero.
// ============================================================================
module asp_graph #(
   parameter int NUM_STATES = 64,
   parameter int MAX_EDGES  = 256,
   parameter int COST_BITS  = 16,
   parameter int NB         = 6,
   parameter int ECW        = 9
) (
   input  wire                   clock,
   input  wire                   reset,
   input  asp_pkg::ld_cmd_type   ld_cmd,
   input  wire  [5:0]            ld_from,
   input  wire  [5:0]            ld_to,
   input  wire  [15:0]           ld_amount,
   input  wire                   e_rd_en,
   input  wire  [ECW-1:0]        e_rd_addr,
   output logic [NB-1:0]         e_from,
   output logic [NB-1:0]         e_to,
   output logic [COST_BITS-1:0]  e_cost,
   output logic [ECW-1:0]        edge_count,
   input  wire                   h_rd_en,
   input  wire  [NB-1:0]         h_rd_addr,
   output logic [COST_BITS-1:0]  h_data
);
   import asp_pkg::*;

   localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int AW = (COST_BITS > 16) ? COST_BITS : 16;
   localparam logic [AW-1:0] COST_MAX = AW'((64'd1 << COST_BITS) - 64'd1);
   localparam logic [6:0] NS7 = 7'(NUM_STATES);
   localparam int EW = 2 * NB + COST_BITS;

   logic [EW-1:0]        emem [MAX_EDGES];
   logic [EW-1:0]        eq_ff;
   logic [COST_BITS-1:0] hmem [NUM_STATES];
   logic [COST_BITS-1:0] hq_ff;
   logic                 hv_q_ff;
   logic [NUM_STATES-1:0] hval_ff, hval_in;
   logic [ECW-1:0]       ecnt_ff, ecnt_in;
   logic [AW-1:0]        amt_wide;
   logic [COST_BITS-1:0] amt_sat;
   logic                 from_ok, to_ok, edge_we, heur_we;

   always_comb begin
      amt_wide = AW'(ld_amount);
      amt_sat  = (amt_wide > COST_MAX) ? COST_BITS'(COST_MAX) : COST_BITS'(amt_wide);
      from_ok  = {1'b0, ld_from} < NS7;
      to_ok    = {1'b0, ld_to} < NS7;
      edge_we  = ld_cmd.add_edge && from_ok && to_ok && (ecnt_ff < ECW'(MAX_EDGES));
      heur_we  = ld_cmd.set_heur && from_ok;
      ecnt_in  = ecnt_ff;
      hval_in  = hval_ff;
      if (ld_cmd.clr) begin
         ecnt_in = '0;
         hval_in = '0;
      end else begin
         if (edge_we) ecnt_in = ecnt_ff + 1'b1;
         if (heur_we) hval_in[ld_from[NB-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff <= '0;
         hval_ff <= '0;
      end else begin
         ecnt_ff <= ecnt_in;
         hval_ff <= hval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) emem[ecnt_ff[EB-1:0]] <= {ld_from[NB-1:0], ld_to[NB-1:0], amt_sat};
      if (e_rd_en) eq_ff <= emem[e_rd_addr[EB-1:0]];
   end

   always_ff @(posedge clock) begin
      if (heur_we) hmem[ld_from[NB-1:0]] <= amt_sat;
      if (h_rd_en) begin
         hq_ff   <= hmem[h_rd_addr];
         hv_q_ff <= hval_ff[h_rd_addr];
      end
   end

   assign e_from     = eq_ff[EW-1 -: NB];
   assign e_to       = eq_ff[COST_BITS +: NB];
   assign e_cost     = eq_ff[COST_BITS-1:0];
   assign edge_count = ecnt_ff;
   assign h_data     = hv_q_ff ? hq_ff : '0;

endmodule
`default_nettype wire

// File: design/asp_frontier.sv
`default_nettype none
// ============================================================================
// asp_frontier: open list of the search
// Append-only entry memory with dead marks. A scan walks all inserted
// entries and keeps the least estimate, the earliest entry on ties.
// ============================================================================
module asp_frontier #(
   parameter int MAX_EDGES = 256,
   parameter int COST_BITS = 16,
   parameter int NB        = 6
) (
   input  wire                   clock,
   input  wire                   reset,
   input  asp_pkg::fr_cmd_type   cmd,
   input  wire  [NB-1:0]         push_node,
   input  wire  [NB-1:0]         push_parent,
   input  wire                   push_start,
   input  wire  [COST_BITS-1:0]  push_est,
   output asp_pkg::fr_stat_type  stat,
   output logic [NB-1:0]         best_node,
   output logic [NB-1:0]         best_parent,
   output logic                  best_start,
   output logic [COST_BITS-1:0]  best_est
);
   import asp_pkg::*;

   localparam int CAP = MAX_EDGES + 1;
   localparam int FB  = $clog2(CAP);
   localparam int PW  = $clog2(CAP + 1);
   localparam int EW  = 2 * NB + 2 + COST_BITS;

   logic [EW-1:0] mem [CAP];
   logic [EW-1:0] q_ff;
   logic [PW-1:0] wptr_ff, live_ff, ridx_ff;
   logic [FB-1:0] qidx_ff, bidx_ff;
   logic          issue_ff, qv_ff, qlast_ff, have_ff, done_ff;
   logic [EW-1:0] best_ff;
   logic          we, take;
   logic [FB-1:0] waddr;
   logic [EW-1:0] wdata;

   always_comb begin
      we    = 1'b0;
      waddr = wptr_ff[FB-1:0];
      wdata = {1'b0, push_start, push_parent, push_node, push_est};
      if (cmd.push && wptr_ff < PW'(CAP)) begin
         we = 1'b1;
      end else if (cmd.kill) begin
         we    = 1'b1;
         waddr = bidx_ff;
         wdata = {1'b1, best_ff[EW-2:0]};
      end
      take = qv_ff && !q_ff[EW-1] &&
             (!have_ff || q_ff[COST_BITS-1:0] < best_ff[COST_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (issue_ff) q_ff <= mem[ridx_ff[FB-1:0]];
      qidx_ff <= ridx_ff[FB-1:0];
      if (take) begin
         best_ff <= q_ff;
         bidx_ff <= qidx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         live_ff  <= '0;
         ridx_ff  <= '0;
         issue_ff <= 1'b0;
         qv_ff    <= 1'b0;
         qlast_ff <= 1'b0;
         have_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         qv_ff    <= issue_ff;
         qlast_ff <= issue_ff && (ridx_ff + 1'b1 == wptr_ff);
         done_ff  <= qv_ff && qlast_ff;
         if (take) have_ff <= 1'b1;
         if (cmd.clr) begin
            wptr_ff <= '0;
            live_ff <= '0;
         end else if (cmd.push && wptr_ff < PW'(CAP)) begin
            wptr_ff <= wptr_ff + 1'b1;
            live_ff <= live_ff + 1'b1;
         end else if (cmd.kill) begin
            live_ff <= live_ff - 1'b1;
         end
         if (cmd.scan) begin
            ridx_ff  <= '0;
            issue_ff <= (wptr_ff != '0);
            have_ff  <= 1'b0;
         end else if (issue_ff) begin
            ridx_ff <= ridx_ff + 1'b1;
            if (ridx_ff + 1'b1 == wptr_ff) issue_ff <= 1'b0;
         end
      end
   end

   assign stat.done   = done_ff;
   assign stat.empty  = (live_ff == '0);
   assign best_est    = best_ff[COST_BITS-1:0];
   assign best_node   = best_ff[COST_BITS +: NB];
   assign best_parent = best_ff[COST_BITS+NB +: NB];
   assign best_start  = best_ff[EW-2];

endmodule
`default_nettype wire

// File: design/astar_shortest_path.sv
`default_nettype none
// ============================================================================
// astar_shortest_path: A* shortest path engine
// Loads a weighted edge list and heuristics, then searches start to goal.
// ============================================================================
// Usage. Input transactions on req_* carry func, node_from, node_to and
// amount. Clear, add-edge and set-heuristic transactions give no result. A
// run transaction searches from the start register to the goal register and
// returns, on rsp_*, the path from the goal back to the start with rsp_last
// on the start, or one not-found result (node 0, found 0, last 1). The csr_*
// channel writes start_node (index 0) and goal_node (index 1); it is always
// ready. The user must write it only while idle; the block does not enforce this.
// Flow. req_ready is high only in the idle state, so one transaction is
// in the block at a time. A run pops the frontier by a scan of all entries
// inserted during the run, and each expansion walks the whole edge list one
// edge at a time, as each table has a single read port. Each path result is
// read from the parent memory, then held on rsp_* until the receiver takes it.
// Reset. Synchronous reset empties the edge list, zeroes all heuristics and
// both registers, and returns to idle with no result pending. A stalled
// receiver simply holds the current result; the search waits with it.
// ============================================================================
module astar_shortest_path #(
   parameter int NUM_STATES = 64,
   parameter int MAX_EDGES  = 256,
   parameter int COST_BITS  = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_func,
   input  wire  [5:0]  req_node_from,
   input  wire  [5:0]  req_node_to,
   input  wire  [15:0] req_amount,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [5:0]  rsp_path_node,
   output logic        rsp_found,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [5:0]  csr_wdata
);
   import asp_pkg::*;

   localparam int NB  = $clog2(NUM_STATES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int SW  = COST_BITS + 2;
   localparam logic [SW-1:0] SUM_MAX = SW'((64'd1 << COST_BITS) - 64'd1);
   localparam logic [6:0] NS7 = 7'(NUM_STATES);

   typedef enum logic [3:0] {
      S_IDLE, S_START_H, S_POP, S_SCAN, S_GCALC, S_E_RD, S_E_CHK, S_E_H,
      S_P_RD, S_P_OUT, S_RSP
   } state_type;

   state_type             state_ff, state_in;
   logic [5:0]            start_ff, goal_ff;
   logic [NUM_STATES-1:0] visited_ff, visited_in;
   logic [NB-1:0]         cur_ff, cur_in, p_ff, p_in, n_ff, n_in;
   logic [COST_BITS-1:0]  est_ff, est_in, g_ff, g_in;
   logic [ECW-1:0]        eidx_ff, eidx_in;
   logic                  rv_ff, rv_in, rf_ff, rf_in, rl_ff, rl_in;
   logic [5:0]            rn_ff, rn_in;
   logic [NB:0]           pmem [NUM_STATES];
   logic [NB:0]           pq_ff;
   logic                  pwe, prd;

   ld_cmd_type            ld_cmd;
   fr_cmd_type            fcmd;
   fr_stat_type           fstat;
   logic [NB-1:0]         push_node, push_parent, best_node, best_parent;
   logic                  push_start, best_start;
   logic [COST_BITS-1:0]  push_est, best_est, e_cost, h_data;
   logic [NB-1:0]         e_from, e_to, h_addr;
   logic                  e_rd_en, h_rd_en, req_acc;
   logic [ECW-1:0]        edge_count;
   logic [SW-1:0]         sum;

   asp_graph #(
      .NUM_STATES(NUM_STATES), .MAX_EDGES(MAX_EDGES), .COST_BITS(COST_BITS),
      .NB(NB), .ECW(ECW)
   ) u_graph (
      .clock(clock), .reset(reset), .ld_cmd(ld_cmd), .ld_from(req_node_from),
      .ld_to(req_node_to), .ld_amount(req_amount), .e_rd_en(e_rd_en),
      .e_rd_addr(eidx_ff), .e_from(e_from), .e_to(e_to), .e_cost(e_cost),
      .edge_count(edge_count), .h_rd_en(h_rd_en), .h_rd_addr(h_addr),
      .h_data(h_data)
   );

   asp_frontier #(
      .MAX_EDGES(MAX_EDGES), .COST_BITS(COST_BITS), .NB(NB)
   ) u_frontier (
      .clock(clock), .reset(reset), .cmd(fcmd), .push_node(push_node),
      .push_parent(push_parent), .push_start(push_start), .push_est(push_est),
      .stat(fstat), .best_node(best_node), .best_parent(best_parent),
      .best_start(best_start), .best_est(best_est)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in   = state_ff;
      visited_in = visited_ff;
      cur_in     = cur_ff;
      est_in     = est_ff;
      g_in       = g_ff;
      eidx_in    = eidx_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      rv_in      = rv_ff;
      rf_in      = rf_ff;
      rl_in      = rl_ff;
      rn_in      = rn_ff;
      ld_cmd     = '0;
      fcmd       = '0;
      push_node  = e_to;
      push_parent = cur_ff;
      push_start = 1'b0;
      sum        = SW'(g_ff) + SW'(e_cost) + SW'(h_data);
      push_est   = (sum > SUM_MAX) ? COST_BITS'(SUM_MAX) : COST_BITS'(sum);
      e_rd_en    = 1'b0;
      h_rd_en    = 1'b0;
      h_addr     = e_to;
      pwe        = 1'b0;
      prd        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_func)
                  FUNC_CLEAR: ld_cmd.clr      = 1'b1;
                  FUNC_EDGE:  ld_cmd.add_edge = 1'b1;
                  FUNC_HEUR:  ld_cmd.set_heur = 1'b1;
                  default: begin
                     if ({1'b0, start_ff} >= NS7) begin
                        rv_in    = 1'b1;
                        rn_in    = '0;
                        rf_in    = 1'b0;
                        rl_in    = 1'b1;
                        state_in = S_RSP;
                     end else begin
                        visited_in = '0;
                        fcmd.clr   = 1'b1;
                        h_rd_en    = 1'b1;
                        h_addr     = start_ff[NB-1:0];
                        state_in   = S_START_H;
                     end
                  end
               endcase
            end
         end
         S_START_H: begin
            // The start entry is marked so that path emission stops there.
            fcmd.push   = 1'b1;
            push_node   = start_ff[NB-1:0];
            push_parent = start_ff[NB-1:0];
            push_start  = 1'b1;
            push_est    = h_data;
            state_in    = S_POP;
         end
         S_POP: begin
            if (fstat.empty) begin
               rv_in    = 1'b1;
               rn_in    = '0;
               rf_in    = 1'b0;
               rl_in    = 1'b1;
               state_in = S_RSP;
            end else begin
               fcmd.scan = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (fstat.done) begin
               fcmd.kill = 1'b1;
               if (visited_ff[best_node]) begin
                  state_in = S_POP;
               end else begin
                  visited_in[best_node] = 1'b1;
                  pwe    = 1'b1;
                  cur_in = best_node;
                  est_in = best_est;
                  if (6'(best_node) == goal_ff) begin
                     p_in     = best_node;
                     n_in     = '0;
                     state_in = S_P_RD;
                  end else begin
                     h_rd_en  = 1'b1;
                     h_addr   = best_node;
                     state_in = S_GCALC;
                  end
               end
            end
         end
         S_GCALC: begin
            // Cost so far is the popped estimate less the node's heuristic.
            g_in     = (est_ff >= h_data) ? est_ff - h_data : '0;
            eidx_in  = '0;
            state_in = S_E_RD;
         end
         S_E_RD: begin
            if (eidx_ff == edge_count) begin
               state_in = S_POP;
            end else begin
               e_rd_en  = 1'b1;
               state_in = S_E_CHK;
            end
         end
         S_E_CHK: begin
            if (e_from == cur_ff && !visited_ff[e_to]) begin
               h_rd_en  = 1'b1;
               state_in = S_E_H;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_E_RD;
            end
         end
         S_E_H: begin
            fcmd.push = 1'b1;
            eidx_in   = eidx_ff + 1'b1;
            state_in  = S_E_RD;
         end
         S_P_RD: begin
            prd      = 1'b1;
            state_in = S_P_OUT;
         end
         S_P_OUT: begin
            rv_in    = 1'b1;
            rn_in    = 6'(p_ff);
            rf_in    = 1'b1;
            rl_in    = pq_ff[NB] || (n_ff == NB'(NUM_STATES - 1));
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) begin
               rv_in = 1'b0;
               if (rl_ff) begin
                  state_in = S_IDLE;
               end else begin
                  p_in     = pq_ff[NB-1:0];
                  n_in     = n_ff + 1'b1;
                  state_in = S_P_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         start_ff   <= '0;
         goal_ff    <= '0;
         visited_ff <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         visited_ff <= visited_in;
         rv_ff      <= rv_in;
         if (csr_valid && csr_ready) begin
            case (csr_index[0])
               CSR_START: start_ff <= csr_wdata;
               CSR_GOAL:  goal_ff  <= csr_wdata;
               default:   start_ff <= start_ff;
            endcase
         end
      end
      cur_ff  <= cur_in;
      est_ff  <= est_in;
      g_ff    <= g_in;
      eidx_ff <= eidx_in;
      p_ff    <= p_in;
      n_ff    <= n_in;
      rf_ff   <= rf_in;
      rl_ff   <= rl_in;
      rn_ff   <= rn_in;
   end

   always_ff @(posedge clock) begin
      if (pwe) pmem[best_node] <= {best_start, best_parent};
      if (prd) pq_ff <= pmem[p_ff];
   end

   assign rsp_valid     = rv_ff;
   assign rsp_path_node = rn_ff;
   assign rsp_found     = rf_ff;
   assign rsp_last      = rl_ff;

endmodule
`default_nettype wire

// File: test/astar_shortest_path_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// astar_shortest_path_tb: self-checking bench for the A* shortest path engine
// Loads edge lists and heuristics, runs searches and compares every path
// transaction with a predictor kept in step with the block, under several
// patterns of sender idling and receiver stalling.
// ============================================================================
module astar_shortest_path_tb;
   import asp_pkg::*;

   localparam int STATES   = 64;
   localparam int EDGE_CAP = 256;
   localparam int FR_CAP   = EDGE_CAP + 1;
   localparam int COST_MAX = 65535;

   typedef struct {
      logic [5:0] node;
      logic       found;
      logic       last;
   } path_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_CLEAR;
   logic [5:0]  req_node_from = '0;
   logic [5:0]  req_node_to = '0;
   logic [15:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_path_node;
   logic        rsp_found;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_START;
   logic [5:0]  csr_wdata = '0;

   astar_shortest_path dut (.*);

   always #1 clock = ~clock;

   // Mirror of the block's tables and registers.
   logic [5:0]  gr_from [EDGE_CAP];
   logic [5:0]  gr_to [EDGE_CAP];
   int unsigned gr_cost [EDGE_CAP];
   int unsigned gr_edges;
   int unsigned gr_heur [STATES];
   logic [5:0]  cfg_start, cfg_goal;

   // Path transactions still owed by the block, oldest first.
   path_step_type pending_path[$];

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned searches = 0;
   int unsigned steps_checked = 0;
   int unsigned not_found_runs = 0;
   int unsigned mismatches = 0;

   // Search one run in the mirror and queue the path it yields.
   task automatic predict_search();
      logic [5:0]  fr_node [FR_CAP];
      int unsigned fr_est [FR_CAP];
      logic [5:0]  fr_par [FR_CAP];
      bit          fr_root [FR_CAP];
      int unsigned fr_n;
      bit          seen [STATES];
      logic [5:0]  link [STATES];
      bit          is_root [STATES];
      int unsigned best, g, est, n;
      logic [5:0]  cur, cur_par, p;
      bit          cur_root, fin;
      path_step_type s;
      foreach (seen[i]) seen[i] = 1'b0;
      fr_n = 1;
      fr_node[0] = cfg_start;
      fr_est[0] = gr_heur[cfg_start];
      fr_par[0] = cfg_start;
      fr_root[0] = 1'b1;
      while (fr_n > 0) begin
         // Lowest estimate wins; ties go to the earliest inserted entry.
         best = 0;
         for (int i = 1; i < fr_n; i++)
            if (fr_est[i] < fr_est[best]) best = i;
         cur = fr_node[best];
         est = fr_est[best];
         cur_par = fr_par[best];
         cur_root = fr_root[best];
         for (int i = best; i + 1 < fr_n; i++) begin
            fr_node[i] = fr_node[i+1];
            fr_est[i] = fr_est[i+1];
            fr_par[i] = fr_par[i+1];
            fr_root[i] = fr_root[i+1];
         end
         fr_n--;
         if (seen[cur]) continue;
         seen[cur] = 1'b1;
         link[cur] = cur_par;
         is_root[cur] = cur_root;
         if (cur == cfg_goal) begin
            p = cur;
            n = 0;
            do begin
               fin = is_root[p] || n == STATES - 1;
               s.node = p;
               s.found = 1'b1;
               s.last = fin;
               pending_path.insert(pending_path.size(), s);
               n++;
               p = link[p];
            end while (!fin);
            return;
         end
         g = (est >= gr_heur[cur]) ? est - gr_heur[cur] : 0;
         for (int i = 0; i < gr_edges; i++) begin
            if (gr_from[i] != cur || seen[gr_to[i]] || fr_n >= FR_CAP) continue;
            est = g + gr_cost[i] + gr_heur[gr_to[i]];
            fr_node[fr_n] = gr_to[i];
            fr_est[fr_n] = (est > COST_MAX) ? COST_MAX : est;
            fr_par[fr_n] = cur;
            fr_root[fr_n] = 1'b0;
            fr_n++;
         end
      end
      not_found_runs++;
      s.node = '0;
      s.found = 1'b0;
      s.last = 1'b1;
      pending_path.insert(pending_path.size(), s);
   endtask

   // Present one input transaction, wait for its acceptance and update the
   // mirror. Valid is left high so a following item can reuse it.
   task automatic send_item(input logic [1:0] f, input logic [5:0] a,
                            input logic [5:0] b, input logic [15:0] amt);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_node_from <= a;
      req_node_to <= b;
      req_amount <= amt;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      case (f)
         FUNC_CLEAR: begin
            gr_edges = 0;
            foreach (gr_heur[i]) gr_heur[i] = 0;
         end
         FUNC_EDGE: begin
            if (gr_edges < EDGE_CAP) begin
               gr_from[gr_edges] = a;
               gr_to[gr_edges] = b;
               gr_cost[gr_edges] = amt;
               gr_edges++;
            end
         end
         FUNC_HEUR: gr_heur[a] = amt;
         FUNC_RUN: begin
            searches++;
            predict_search();
         end
         default: begin
         end
      endcase
   endtask

   // Drop valid, let every owed result arrive, then let the block return to idle.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_path.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write both search registers while the block is idle.
   task automatic set_endpoints(input logic [5:0] s, input logic [5:0] g);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= CSR_START;
      csr_wdata <= s;
      do @(posedge clock); while (!csr_ready);
      cfg_start = s;
      csr_index <= CSR_GOAL;
      csr_wdata <= g;
      do @(posedge clock); while (!csr_ready);
      cfg_goal = g;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Checker: every accepted path transaction must match the oldest
   // expectation field by field.
   always @(posedge clock) begin
      path_step_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_path.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: node %0d found %0b last %0b",
                        rsp_path_node, rsp_found, rsp_last);
         end else begin
            want = pending_path.pop_front();
            steps_checked++;
            if (rsp_path_node !== want.node || rsp_found !== want.found ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected node %0d found %0b last %0b, got %0d %0b %0b",
                           want.node, want.found, want.last,
                           rsp_path_node, rsp_found, rsp_last);
            end
         end
      end
   end

   // Extremes, every operation and the special cases of the search.
   task automatic test_directed();
      // Empty tables with start equal to goal: a one-step path.
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      // Goal unreachable: the single not-found transaction.
      set_endpoints(6'd0, 6'd63);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      // Two routes of equal estimate to test the tie rule, with maximal
      // costs and heuristics that force estimate saturation.
      send_item(FUNC_EDGE, 6'd0, 6'd5, 16'd10);
      send_item(FUNC_EDGE, 6'd0, 6'd7, 16'd10);
      send_item(FUNC_EDGE, 6'd5, 6'd63, 16'd1);
      send_item(FUNC_EDGE, 6'd7, 6'd63, 16'd1);
      send_item(FUNC_EDGE, 6'd0, 6'd63, 16'hFFFF);
      send_item(FUNC_HEUR, 6'd63, 6'd0, 16'd0);
      send_item(FUNC_HEUR, 6'd5, 6'd63, 16'hFFFF);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      send_item(FUNC_HEUR, 6'd5, 6'd0, 16'd0);
      send_item(FUNC_EDGE, 6'd63, 6'd0, 16'd0);
      send_item(FUNC_RUN, 6'd63, 6'd63, 16'hFFFF);
      // Reverse direction, including a self loop on the start.
      set_endpoints(6'd63, 6'd7);
      send_item(FUNC_EDGE, 6'd63, 6'd63, 16'd3);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      set_endpoints(6'd63, 6'd63);
      send_item(FUNC_RUN, 6'd21, 6'd42, 16'h5555);
      // A clear wipes edges and heuristics alike.
      set_endpoints(6'd0, 6'd5);
      send_item(FUNC_CLEAR, 6'd63, 6'd63, 16'hFFFF);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      wait_quiet();
   endtask

   // Fill the edge list, then show that one more edge is dropped.
   task automatic test_edge_overflow();
      set_endpoints(6'd0, 6'd1);
      send_item(FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
      for (int i = 0; i < EDGE_CAP; i++)
         send_item(FUNC_EDGE, 6'd62 - 6'(i % 4), 6'(i % 64), 16'($urandom));
      send_item(FUNC_EDGE, 6'd0, 6'd1, 16'd1);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      send_item(FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
      wait_quiet();
   endtask

   // Mostly well-formed graph builds ending in a search, with some noise.
   task automatic test_random_graphs(input int unsigned n_items,
                                     input int unsigned idle, input int unsigned stall);
      int unsigned stop_at;
      logic [5:0]  base;
      int unsigned k;
      idle_pct = idle;
      stall_pct = stall;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         base = 6'($urandom);
         if ($urandom_range(99) < 80) begin
            // Small graph on eight neighbouring states.
            if ($urandom_range(3) != 0)
               set_endpoints(base + 6'($urandom_range(7)), base + 6'($urandom_range(7)));
            send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
            k = $urandom_range(3, 12);
            repeat (k)
               send_item(FUNC_EDGE, base + 6'($urandom_range(7)),
                         base + 6'($urandom_range(7)),
                         ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20)));
            repeat ($urandom_range(4))
               send_item(FUNC_HEUR, base + 6'($urandom_range(7)), 6'($urandom),
                         ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(10)));
            send_item(FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
         end else begin
            // Noise: any operation with fields spread over their full range.
            send_item(2'($urandom_range(2)), 6'($urandom), 6'($urandom), 16'($urandom));
            if ($urandom_range(3) == 0)
               send_item(FUNC_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
         end
      end
      wait_quiet();
   endtask

   // The sender holds off until the search has fully drained.
   task automatic test_drain_pause();
      idle_pct = 0;
      stall_pct = 50;
      set_endpoints(6'd10, 6'd12);
      send_item(FUNC_CLEAR, 6'd0, 6'd0, 16'd0);
      send_item(FUNC_EDGE, 6'd10, 6'd11, 16'd2);
      send_item(FUNC_EDGE, 6'd11, 6'd12, 16'd2);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_path.size() != 0) @(posedge clock);
      send_item(FUNC_RUN, 6'd0, 6'd0, 16'd0);
      wait_quiet();
   endtask

   initial begin
      gr_edges = 0;
      foreach (gr_heur[i]) gr_heur[i] = 0;
      cfg_start = '0;
      cfg_goal = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_edge_overflow();
      test_random_graphs(60, 0, 0);
      test_random_graphs(40, 67, 0);
      test_random_graphs(40, 0, 67);
      test_random_graphs(40, 26, 26);
      test_drain_pause();
      wait_quiet();

      $display("Covered %0d input transactions, %0d searches (%0d without a path).",
               items_sent, searches, not_found_runs);
      $display("Checked %0d path transactions, %0d mismatches.", steps_checked, mismatches);
      if (mismatches == 0 && pending_path.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
design/asp_pkg.sv
design/asp_graph.sv
design/asp_frontier.sv
design/astar_shortest_path.sv
test/astar_shortest_path_tb.sv
